// ===== sv/rci_pkg.sv =====
// ----------------------------------------------------------------------------
// rci_pkg
// Shared types, step codes and helper functions of the rating curve
// interpolator.
// ----------------------------------------------------------------------------
package rci_pkg;

    localparam int MAX_ROWS = 32;
    localparam int ROW_W    = $clog2(MAX_ROWS);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_POINTS    = 2'd0;
    localparam logic [1:0] REG_BED_SLOPE = 2'd1;
    localparam logic [1:0] REG_REF_N     = 2'd2;
    localparam logic [1:0] REG_MIN_STAGE = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NONPOS = 2'd1;
    localparam logic [1:0] STAT_ZDIV   = 2'd2;

    localparam logic [1:0] COL_STAGE = 2'd0;
    localparam logic [1:0] COL_WIDTH = 2'd1;
    localparam logic [1:0] COL_AREA  = 2'd2;
    localparam logic [1:0] COL_PERIM = 2'd3;

    // sequencer steps
    localparam logic [4:0] ST_IDLE       = 5'd0;
    localparam logic [4:0] ST_PREP       = 5'd1;
    localparam logic [4:0] ST_SLP_GO     = 5'd2;
    localparam logic [4:0] ST_SLP_WAIT   = 5'd3;
    localparam logic [4:0] ST_SQRT_GO    = 5'd4;
    localparam logic [4:0] ST_SQRT_WAIT  = 5'd5;
    localparam logic [4:0] ST_SLP_MUL    = 5'd6;
    localparam logic [4:0] ST_SLP_FIX    = 5'd7;
    localparam logic [4:0] ST_MAN_MUL    = 5'd8;
    localparam logic [4:0] ST_MAN_GO     = 5'd9;
    localparam logic [4:0] ST_MAN_WAIT   = 5'd10;
    localparam logic [4:0] ST_QS         = 5'd11;
    localparam logic [4:0] ST_SRCH_RD    = 5'd12;
    localparam logic [4:0] ST_SRCH_CMP   = 5'd13;
    localparam logic [4:0] ST_LO_RD      = 5'd14;
    localparam logic [4:0] ST_LO_LAT     = 5'd15;
    localparam logic [4:0] ST_HI_LAT     = 5'd16;
    localparam logic [4:0] ST_LERP_MUL   = 5'd17;
    localparam logic [4:0] ST_LERP_GO    = 5'd18;
    localparam logic [4:0] ST_LERP_WAIT  = 5'd19;
    localparam logic [4:0] ST_LERP_FIN   = 5'd20;
    localparam logic [4:0] ST_DEPTH      = 5'd21;
    localparam logic [4:0] ST_CEL        = 5'd22;
    localparam logic [4:0] ST_CEL_WAIT   = 5'd23;
    localparam logic [4:0] ST_DIFF       = 5'd24;
    localparam logic [4:0] ST_DIFF1_WAIT = 5'd25;
    localparam logic [4:0] ST_DIFF2_GO   = 5'd26;
    localparam logic [4:0] ST_DIFF2_WAIT = 5'd27;
    localparam logic [4:0] ST_NEG_RD     = 5'd28;
    localparam logic [4:0] ST_NEG_LAT    = 5'd29;
    localparam logic [4:0] ST_NEG_SET    = 5'd30;
    localparam logic [4:0] ST_FIN        = 5'd31;

    typedef struct packed {
        logic               op;
        logic [4:0]         row;
        logic [30:0]        row_flow;
        logic signed [31:0] row_stage;
        logic [30:0]        row_width;
        logic [30:0]        row_area;
        logic [30:0]        row_perimeter;
        logic signed [31:0] query_flow;
        logic [31:0]        local_slope;
        logic               use_local_slope;
        logic [31:0]        local_manning;
        logic               use_local_manning;
    } in_t;

    typedef struct packed {
        logic signed [31:0] stage_out;
        logic signed [31:0] depth_out;
        logic signed [31:0] width_out;
        logic signed [31:0] area_out;
        logic signed [31:0] perimeter_out;
        logic signed [31:0] celerity_out;
        logic signed [31:0] diffusivity_out;
        logic [1:0]         status;
    } out_t;

    typedef struct packed {
        logic [30:0] flow;
        logic [31:0] stage;
        logic [30:0] width;
        logic [30:0] area;
        logic [30:0] perim;
    } row_t;

    typedef struct packed {
        logic [4:0] step;
        logic [1:0] col;
        logic       take;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic q_neg;
        logic ls_go;
        logic lm_go;
        logic more;
        logic dq_zero;
        logic da_zero;
        logic diff_div;
        logic t_big;
    } sts_t;

    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic [32:0] abs33(input logic [32:0] x);
        return x[32] ? (~x + 33'd1) : x;
    endfunction

    function automatic logic [31:0] sat44(input logic signed [43:0] x);
        if (x > 44'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -44'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    // magnitude plus sign to saturated 32-bit two's complement
    function automatic logic [31:0] ssat(input logic [63:0] m, input logic neg);
        if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
        return (m >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

endpackage

// ===== sv/rci_div.sv =====
// ----------------------------------------------------------------------------
// rci_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module rci_div import rci_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quotient,
    output logic        done
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] dsr_reg;
    logic [32:0] shifted;
    logic [32:0] trial;
    logic        take;

    assign shifted = {rem_reg, quo_reg[63]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign take    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= take ? trial[31:0] : shifted[31:0];
            quo_reg <= {quo_reg[62:0], take};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== sv/rci_sqrt.sv =====
// ----------------------------------------------------------------------------
// rci_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module rci_sqrt import rci_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic [31:0] root,
    output logic        done
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [35:0] shifted;
    logic [35:0] trial;
    logic        take;

    assign shifted = {rem_reg, x_reg[63:62]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign take    = shifted >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[61:0], 2'b00};
            rem_reg  <= take ? 34'(shifted - trial) : shifted[33:0];
            root_reg <= {root_reg[30:0], take};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ===== sv/rci_datapath.sv =====
// ----------------------------------------------------------------------------
// rci_datapath
// Configuration registers, rating table memory, multiplier, divider and
// square root units, and the result registers.
// ----------------------------------------------------------------------------
module rci_datapath import rci_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  in_t         s_data,
    output out_t        m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    row_t               mem [MAX_ROWS];
    row_t               rd_reg;
    row_t               lo_reg;
    row_t               hi_reg;
    logic [ROW_W-1:0]   raddr;

    logic [5:0]         pts_reg;
    logic [31:0]        bed_reg;
    logic [31:0]        refn_reg;
    logic [31:0]        minst_reg;

    logic [31:0]        q_reg;
    logic [31:0]        lslope_reg;
    logic [31:0]        lman_reg;
    logic               ls_reg;
    logic               lm_reg;

    logic               satq_reg;
    logic               zdiv_reg;
    logic               sign_reg;
    logic [63:0]        m_reg;
    logic [30:0]        qs_reg;
    logic [ROW_W-1:0]   k_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        stage_reg;
    logic [31:0]        width_reg;
    logic [31:0]        area_reg;
    logic [31:0]        perim_reg;
    logic [31:0]        depth_reg;
    logic [31:0]        celer_reg;
    logic [31:0]        diff_reg;
    out_t               out_reg;

    logic [5:0]         n_eff;
    logic [5:0]         n_m2;
    logic               q_neg;
    logic               q_pos;
    logic [31:0]        s_sel;
    logic [32:0]        tab_lo;
    logic [32:0]        tab_hi;
    logic [31:0]        dq;
    logic [31:0]        da;
    logic [31:0]        n1;
    logic [32:0]        n2;
    logic [32:0]        n2_abs;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic               div_start;
    logic [63:0]        div_a;
    logic [31:0]        div_b;
    logic [63:0]        div_q;
    logic               div_done;
    logic [31:0]        sq_root;
    logic               sq_done;
    logic [40:0]        quo_cap;
    logic signed [43:0] lerp_sum;
    logic signed [43:0] depth_sum;
    logic [47:0]        slp_shift;
    logic [1:0]         status_val;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pts_reg   <= 6'd20;
            bed_reg   <= 32'd268435;
            refn_reg  <= 32'd2684355;
            minst_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_POINTS:    pts_reg   <= cfg_wdata[5:0];
                REG_BED_SLOPE: bed_reg   <= cfg_wdata;
                REG_REF_N:     refn_reg  <= cfg_wdata;
                REG_MIN_STAGE: minst_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign n_eff = (pts_reg < 6'd2) ? 6'd2 :
                   (pts_reg > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : pts_reg;
    assign n_m2  = n_eff - 6'd2;

    // table memory
    always_comb begin
        unique case (cmd.step)
            ST_SRCH_RD, ST_LO_LAT: raddr = k_reg + ROW_W'(1);
            ST_NEG_RD:             raddr = '0;
            default:               raddr = k_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && s_data.op == OP_WRITE) begin
            mem[s_data.row[ROW_W-1:0]] <= '{flow: s_data.row_flow, stage: s_data.row_stage,
                                          width: s_data.row_width, area: s_data.row_area,
                                          perim: s_data.row_perimeter};
        end
        rd_reg <= mem[raddr];
    end

    // interval terms
    always_comb begin
        case (cmd.col)
            COL_STAGE: begin
                tab_lo = {lo_reg.stage[31], lo_reg.stage};
                tab_hi = {hi_reg.stage[31], hi_reg.stage};
            end
            COL_WIDTH: begin
                tab_lo = {2'b00, lo_reg.width};
                tab_hi = {2'b00, hi_reg.width};
            end
            COL_AREA: begin
                tab_lo = {2'b00, lo_reg.area};
                tab_hi = {2'b00, hi_reg.area};
            end
            default: begin
                tab_lo = {2'b00, lo_reg.perim};
                tab_hi = {2'b00, hi_reg.perim};
            end
        endcase
    end

    assign q_neg  = q_reg[31];
    assign q_pos  = !q_reg[31] && (q_reg != '0);
    assign s_sel  = ls_reg ? lslope_reg : bed_reg;
    assign dq     = {1'b0, hi_reg.flow} - {1'b0, lo_reg.flow};
    assign da     = {1'b0, hi_reg.area} - {1'b0, lo_reg.area};
    assign n1     = {1'b0, qs_reg} - {1'b0, lo_reg.flow};
    assign n2     = tab_hi - tab_lo;
    assign n2_abs = abs33(n2);

    // shared multiplier
    always_comb begin
        unique case (cmd.step)
            ST_SLP_MUL: begin
                mul_a = m_reg[31:0];
                mul_b = sq_root;
            end
            ST_MAN_MUL: begin
                mul_a = m_reg[31:0];
                mul_b = lman_reg;
            end
            default: begin
                mul_a = abs32(n1);
                mul_b = n2_abs[31:0];
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // shared divider
    always_comb begin
        div_start = 1'b0;
        div_a     = prod_reg;
        div_b     = refn_reg;
        unique case (cmd.step)
            ST_SLP_GO: begin
                div_start = 1'b1;
                div_a     = {bed_reg, 32'h0};
                div_b     = lslope_reg;
            end
            ST_MAN_GO: begin
                div_start = 1'b1;
            end
            ST_LERP_GO: begin
                div_start = 1'b1;
                div_b     = abs32(dq);
            end
            ST_CEL: begin
                div_start = da != '0;
                div_a     = {16'h0, abs32(dq), 16'h0};
                div_b     = abs32(da);
            end
            ST_DIFF: begin
                div_start = sts.diff_div;
                div_a     = {q_reg, 32'h0};
                div_b     = abs32(depth_reg);
            end
            ST_DIFF2_GO: begin
                div_start = 1'b1;
                div_a     = {div_q[52:0], 11'h0};
                div_b     = s_sel;
            end
            default: ;
        endcase
    end

    rci_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .done     (div_done)
    );

    rci_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.step == ST_SQRT_GO),
        .radicand (div_q),
        .root     (sq_root),
        .done     (sq_done)
    );

    assign quo_cap   = (div_q > 64'h100_0000_0000) ? 41'h100_0000_0000 : div_q[40:0];
    assign lerp_sum  = sign_reg ? ({{11{tab_lo[32]}}, tab_lo} - {3'b000, quo_cap})
                                : ({{11{tab_lo[32]}}, tab_lo} + {3'b000, quo_cap});
    assign depth_sum = {{12{stage_reg[31]}}, stage_reg} - {{12{minst_reg[31]}}, minst_reg};
    assign slp_shift = prod_reg[63:16];

    assign status_val = !q_pos ? STAT_NONPOS : (zdiv_reg ? STAT_ZDIV : STAT_OK);

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            q_reg      <= s_data.query_flow;
            lslope_reg <= s_data.local_slope;
            lman_reg   <= s_data.local_manning;
            ls_reg     <= s_data.use_local_slope;
            lm_reg     <= s_data.use_local_manning;
        end
        unique case (cmd.step)
            ST_PREP: begin
                m_reg    <= {32'h0, q_reg};
                satq_reg <= ls_reg && (lslope_reg == '0);
                zdiv_reg <= 1'b0;
            end
            ST_SLP_MUL, ST_MAN_MUL: prod_reg <= mul_p;
            ST_SLP_FIX: m_reg <= {32'h0, (slp_shift[47:32] != '0) ? 32'hFFFF_FFFF
                                                                  : slp_shift[31:0]};
            ST_MAN_WAIT: if (div_done) m_reg <= div_q;
            ST_QS: begin
                if (satq_reg || (lm_reg && refn_reg == '0)) begin
                    zdiv_reg <= 1'b1;
                    qs_reg   <= (q_reg == '0) ? 31'h0 : 31'h7FFF_FFFF;
                end else begin
                    qs_reg <= (m_reg >= 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : m_reg[30:0];
                end
                k_reg <= '0;
            end
            ST_SRCH_CMP: if (sts.more) k_reg <= k_reg + ROW_W'(1);
            ST_LO_LAT, ST_NEG_LAT: lo_reg <= rd_reg;
            ST_HI_LAT: hi_reg <= rd_reg;
            ST_LERP_MUL: begin
                if (dq == '0) begin
                    zdiv_reg <= 1'b1;
                    case (cmd.col)
                        COL_STAGE: stage_reg <= tab_lo[31:0];
                        COL_WIDTH: width_reg <= tab_lo[31:0];
                        COL_AREA:  area_reg  <= tab_lo[31:0];
                        default:   perim_reg <= tab_lo[31:0];
                    endcase
                end else begin
                    prod_reg <= mul_p;
                    sign_reg <= (n1[31] != n2[32]) ? !dq[31] : dq[31];
                end
            end
            ST_LERP_FIN: begin
                case (cmd.col)
                    COL_STAGE: stage_reg <= sat44(lerp_sum);
                    COL_WIDTH: width_reg <= sat44(lerp_sum);
                    COL_AREA:  area_reg  <= sat44(lerp_sum);
                    default:   perim_reg <= sat44(lerp_sum);
                endcase
            end
            ST_NEG_SET: begin
                stage_reg <= lo_reg.stage;
                width_reg <= {1'b0, lo_reg.width};
                area_reg  <= {1'b0, lo_reg.area};
                perim_reg <= {1'b0, lo_reg.perim};
                celer_reg <= '0;
                diff_reg  <= '0;
            end
            ST_DEPTH: depth_reg <= sat44(depth_sum);
            ST_CEL: begin
                if (da == '0) begin
                    zdiv_reg  <= 1'b1;
                    celer_reg <= (dq == '0) ? 32'h0 : (dq[31] ? 32'h8000_0000 : 32'h7FFF_FFFF);
                end
            end
            ST_CEL_WAIT: if (div_done) celer_reg <= ssat(div_q, dq[31] != da[31]);
            ST_DIFF: begin
                if (!q_pos) begin
                    diff_reg <= '0;
                end else if (!sts.diff_div) begin
                    zdiv_reg <= 1'b1;
                    diff_reg <= 32'h7FFF_FFFF;
                end
            end
            ST_DIFF1_WAIT: begin
                if (div_done && sts.t_big) begin
                    diff_reg <= depth_reg[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
            end
            ST_DIFF2_WAIT: if (div_done) diff_reg <= ssat(div_q, depth_reg[31]);
            default: ;
        endcase
        if (cmd.load_out) begin
            out_reg <= '{stage_out: stage_reg, depth_out: depth_reg, width_out: width_reg,
                         area_out: area_reg, perimeter_out: perim_reg,
                         celerity_out: celer_reg, diffusivity_out: diff_reg,
                         status: status_val};
        end
    end

    assign m_data = out_reg;

    assign sts.div_done  = div_done;
    assign sts.sqrt_done = sq_done;
    assign sts.q_neg     = q_neg;
    assign sts.ls_go     = ls_reg && (lslope_reg != '0);
    assign sts.lm_go     = lm_reg && !satq_reg && (refn_reg != '0);
    assign sts.more      = ({1'b0, k_reg} < n_m2) && (qs_reg > rd_reg.flow);
    assign sts.dq_zero   = dq == '0;
    assign sts.da_zero   = da == '0;
    assign sts.diff_div  = q_pos && (depth_reg != '0) && (s_sel != '0);
    assign sts.t_big     = div_q[63:52] != '0;

endmodule

// ===== sv/rci_ctrl.sv =====
// ----------------------------------------------------------------------------
// rci_ctrl
// Query sequencer: steps the datapath through scaling, search, interpolation
// and the derived terms, and owns both handshakes.
// ----------------------------------------------------------------------------
module rci_ctrl import rci_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_op,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [1:0] col_reg;
    logic [1:0] col_next;
    logic       m_valid_reg;
    logic       load;

    assign load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid && s_op == OP_QUERY) state_next = ST_PREP;
            ST_PREP:      state_next = sts.q_neg ? ST_NEG_RD :
                                       (sts.ls_go ? ST_SLP_GO : ST_MAN_MUL);
            ST_SLP_GO:    state_next = ST_SLP_WAIT;
            ST_SLP_WAIT:  if (sts.div_done) state_next = ST_SQRT_GO;
            ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT: if (sts.sqrt_done) state_next = ST_SLP_MUL;
            ST_SLP_MUL:   state_next = ST_SLP_FIX;
            ST_SLP_FIX:   state_next = ST_MAN_MUL;
            ST_MAN_MUL:   state_next = sts.lm_go ? ST_MAN_GO : ST_QS;
            ST_MAN_GO:    state_next = ST_MAN_WAIT;
            ST_MAN_WAIT:  if (sts.div_done) state_next = ST_QS;
            ST_QS:        state_next = ST_SRCH_RD;
            ST_SRCH_RD:   state_next = ST_SRCH_CMP;
            ST_SRCH_CMP:  state_next = sts.more ? ST_SRCH_RD : ST_LO_RD;
            ST_LO_RD:     state_next = ST_LO_LAT;
            ST_LO_LAT:    state_next = ST_HI_LAT;
            ST_HI_LAT: begin
                col_next   = COL_STAGE;
                state_next = ST_LERP_MUL;
            end
            ST_LERP_MUL: begin
                if (!sts.dq_zero) begin
                    state_next = ST_LERP_GO;
                end else if (col_reg == COL_PERIM) begin
                    state_next = ST_DEPTH;
                end else begin
                    col_next = col_reg + 2'd1;
                end
            end
            ST_LERP_GO:   state_next = ST_LERP_WAIT;
            ST_LERP_WAIT: if (sts.div_done) state_next = ST_LERP_FIN;
            ST_LERP_FIN: begin
                if (col_reg == COL_PERIM) begin
                    state_next = ST_DEPTH;
                end else begin
                    col_next   = col_reg + 2'd1;
                    state_next = ST_LERP_MUL;
                end
            end
            ST_DEPTH:      state_next = sts.q_neg ? ST_FIN : ST_CEL;
            ST_CEL:        state_next = sts.da_zero ? ST_DIFF : ST_CEL_WAIT;
            ST_CEL_WAIT:   if (sts.div_done) state_next = ST_DIFF;
            ST_DIFF:       state_next = sts.diff_div ? ST_DIFF1_WAIT : ST_FIN;
            ST_DIFF1_WAIT: if (sts.div_done) state_next = sts.t_big ? ST_FIN : ST_DIFF2_GO;
            ST_DIFF2_GO:   state_next = ST_DIFF2_WAIT;
            ST_DIFF2_WAIT: if (sts.div_done) state_next = ST_FIN;
            ST_NEG_RD:     state_next = ST_NEG_LAT;
            ST_NEG_LAT:    state_next = ST_NEG_SET;
            ST_NEG_SET:    state_next = ST_DEPTH;
            ST_FIN:        if (load) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= COL_STAGE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            // hold the word until taken, refill from the finished query
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready      = state_reg == ST_IDLE;
    assign m_valid      = m_valid_reg;
    assign cmd.step     = state_reg;
    assign cmd.col      = col_reg;
    assign cmd.take     = s_valid && (state_reg == ST_IDLE);
    assign cmd.load_out = load;

endmodule

// ===== sv/rating_curve_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// rating_curve_interpolator_top
// Rating table interpolator: row loads and flow queries on one valid/ready
// channel, one result word per query.
// ----------------------------------------------------------------------------
// A row write is taken in the idle state and leaves the sequencer idle. A query with a
// negative flow reads row 0 and skips the scaling, the search and every division; any
// other query runs the scaling, the table search, the interpolation of four columns and
// the derived terms. Its time is set by the shared one-bit-per-cycle divider (up to
// nine divisions: slope ratio, roughness, four columns, celerity and two for
// diffusivity), the square root and the table search through the registered memory
// read port.
// The result sits in an output register, so the next word is accepted while a
// result waits.
module rating_curve_interpolator_top import rci_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    rci_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rci_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// ===== test/rating_curve_interpolator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rating_curve_interpolator_top_tb
// Loads rating tables, sweeps register settings and queries the interpolator
// with directed and random words; every result word is checked field by field
// against a behavioral model of the table search and interpolation.
// ----------------------------------------------------------------------------
module rating_curve_interpolator_top_tb;
    import rci_pkg::*;

    localparam longint LIMIT = 64'd6_000_000;
    localparam longint S_HI = 64'sd2147483647;
    localparam longint S_LO = -64'sd2147483648;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_POINTS;
    logic [31:0] cfg_wdata = '0;

    rating_curve_interpolator_top dut (.*);

    always #5 aclk = ~aclk;

    // model state
    longint tab_flow[MAX_ROWS], tab_stage[MAX_ROWS], tab_width[MAX_ROWS];
    longint tab_area[MAX_ROWS], tab_perim[MAX_ROWS];
    int     n_points = 20;
    longint bed = 268435, ref_n = 2684355, datum = 0;

    out_t   pending_results[$];
    int     errors = 0;
    longint cycles = 0;
    int     stall_left = 0;
    logic   sink_random = 1'b1;

    function automatic longint sat32(longint x);
        if (x > S_HI) return S_HI;
        if (x < S_LO) return S_LO;
        return x;
    endfunction

    function automatic longint mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint sat_sign(longint unsigned m, bit neg);
        if (neg) return m >= 64'd2147483648 ? S_LO : -longint'(m);
        return m >= 64'd2147483647 ? S_HI : longint'(m);
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint interp_col(longint qs, int k, int col, inout bit zdiv);
        longint lo, hi, dq, n1, n2;
        longint unsigned quo;
        case (col)
            0: begin lo = tab_stage[k]; hi = tab_stage[k+1]; end
            1: begin lo = tab_width[k]; hi = tab_width[k+1]; end
            2: begin lo = tab_area[k]; hi = tab_area[k+1]; end
            default: begin lo = tab_perim[k]; hi = tab_perim[k+1]; end
        endcase
        dq = tab_flow[k+1] - tab_flow[k];
        if (dq == 0) begin
            zdiv = 1'b1;
            return sat32(lo);
        end
        n1 = qs - tab_flow[k];
        n2 = hi - lo;
        quo = (unsigned'(mag(n1)) * unsigned'(mag(n2))) / unsigned'(mag(dq));
        if (quo > 64'd1099511627776) quo = 64'd1099511627776;
        if (((n1 < 0) != (n2 < 0)) ? !(dq < 0) : (dq < 0))
            return sat32(lo - longint'(quo));
        return sat32(lo + longint'(quo));
    endfunction

    // apply one word to the model; returns 1 when it produces a result
    function automatic bit interpolate(in_t w, output out_t r);
        longint q, qs, st, dp, wd, ar, pm, cel = 0, dif = 0;
        longint unsigned m, s, t, ls_v, lm_v;
        bit zdiv = 0, satq = 0;
        int n, k = 0;
        logic [1:0] stat;
        r = '0;
        if (w.op == OP_WRITE) begin
            tab_flow[w.row]  = w.row_flow;
            tab_stage[w.row] = longint'(w.row_stage);
            tab_width[w.row] = w.row_width;
            tab_area[w.row]  = w.row_area;
            tab_perim[w.row] = w.row_perimeter;
            return 0;
        end
        n = n_points < 2 ? 2 : (n_points > MAX_ROWS ? MAX_ROWS : n_points);
        q = longint'(w.query_flow);
        ls_v = w.local_slope;
        lm_v = w.local_manning;
        if (q < 0) begin
            st = sat32(tab_stage[0]);
            wd = tab_width[0];
            ar = tab_area[0];
            pm = tab_perim[0];
            dp = sat32(st - datum);
            stat = STAT_NONPOS;
        end else begin
            m = q;
            if (w.use_local_slope) begin
                if (ls_v == 0) satq = 1;
                else begin
                    m = (m * root64((unsigned'(bed) << 32) / ls_v)) >> 16;
                    if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
                end
            end
            if (w.use_local_manning && !satq) begin
                if (ref_n == 0) satq = 1;
                else m = (m * lm_v) / unsigned'(ref_n);
            end
            if (satq) begin
                zdiv = 1;
                m = (q == 0) ? 0 : 64'hFFFF_FFFF;
            end
            qs = sat_sign(m, 1'b0);
            while (k < n - 2 && qs > tab_flow[k+1]) k++;
            st = interp_col(qs, k, 0, zdiv);
            wd = interp_col(qs, k, 1, zdiv);
            ar = interp_col(qs, k, 2, zdiv);
            pm = interp_col(qs, k, 3, zdiv);
            dp = sat32(st - datum);
            begin
                longint dq, da;
                dq = tab_flow[k+1] - tab_flow[k];
                da = tab_area[k+1] - tab_area[k];
                if (da == 0) begin
                    zdiv = 1;
                    cel = dq > 0 ? S_HI : (dq < 0 ? S_LO : 0);
                end else begin
                    cel = sat_sign((unsigned'(mag(dq)) << 16)
                                   / unsigned'(mag(da)), (dq < 0) != (da < 0));
                end
            end
            if (q > 0) begin
                s = w.use_local_slope ? ls_v : unsigned'(bed);
                if (dp == 0 || s == 0) begin
                    zdiv = 1;
                    dif = S_HI;
                end else begin
                    t = (unsigned'(q) << 32) / unsigned'(mag(dp));
                    if (t >= (64'd1 << 52)) dif = dp < 0 ? S_LO : S_HI;
                    else dif = sat_sign((t << 11) / s, dp < 0);
                end
                stat = zdiv ? STAT_ZDIV : STAT_OK;
            end else begin
                stat = STAT_NONPOS;
            end
        end
        r.stage_out = st[31:0];
        r.depth_out = dp[31:0];
        r.width_out = wd[31:0];
        r.area_out = ar[31:0];
        r.perimeter_out = pm[31:0];
        r.celerity_out = cel[31:0];
        r.diffusivity_out = dif[31:0];
        r.status = stat;
        return 1;
    endfunction

    task automatic compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // result side: random stalls while sink_random is set, checks against the oldest expectation
    always @(posedge aclk) begin
        out_t e;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                compare("stage_out", e.stage_out, m_data.stage_out);
                compare("depth_out", e.depth_out, m_data.depth_out);
                compare("width_out", e.width_out, m_data.width_out);
                compare("area_out", e.area_out, m_data.area_out);
                compare("perimeter_out", e.perimeter_out, m_data.perimeter_out);
                compare("celerity_out", e.celerity_out, m_data.celerity_out);
                compare("diffusivity_out", e.diffusivity_out, m_data.diffusivity_out);
                compare("status", {30'd0, e.status}, {30'd0, m_data.status});
            end
        end
        if (!sink_random) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            // hold off the sink for a long stretch
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) == 0) begin
            stall_left <= int'($urandom_range(20, 200));
        end else if ($urandom_range(0, 9) < 2) begin
            m_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ~m_ready;
        end else begin
            m_ready <= m_ready | ($urandom_range(0, 3) == 0);
        end
        if (cycles > LIMIT) begin
            $display("rating_curve_interpolator_top verification failed");
            $finish;
        end
    end

    // drop valid only when a real gap follows
    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // present one word and hold it until accepted
    task automatic send(in_t w, bit has_exp, out_t exp_v);
        out_t r;
        if (interpolate(w, r)) begin
            if (has_exp) begin
                if (r !== exp_v) begin
                    $error("directed row: table value %h, model %h", exp_v, r);
                    errors++;
                end
            end
            pending_results.push_back(r);
        end
        s_data <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if ($urandom_range(0, 2) != 0) idle_gap();
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        s_valid <= 1'b0;
        // drain the block before touching a register
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (800) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POINTS:    n_points = v[5:0];
            REG_BED_SLOPE: bed = v;
            REG_REF_N:     ref_n = v;
            default:       datum = longint'(signed'(v));
        endcase
    endtask

    function automatic in_t row_word(int r, longint fl, longint st);
        in_t w;
        w = '0;
        w.op = OP_WRITE;
        w.row = 5'(r);
        w.row_flow = 31'(fl);
        w.row_stage = 32'(st);
        w.row_width = 31'($urandom());
        w.row_area = 31'($urandom());
        w.row_perimeter = 31'($urandom());
        return w;
    endfunction

    function automatic in_t query_word(longint q, bit ls, logic [31:0] lsv,
                                       bit lm, logic [31:0] lmv);
        in_t w;
        w = '0;
        w.op = OP_QUERY;
        w.query_flow = 32'(q);
        w.use_local_slope = ls;
        w.local_slope = lsv;
        w.use_local_manning = lm;
        w.local_manning = lmv;
        w.row = 5'($urandom());
        return w;
    endfunction

    // monotone table with random content; sometimes flat steps and wide ranges
    task automatic load_table();
        longint fl;
        fl = $urandom_range(0, 2000);
        for (int r = 0; r < MAX_ROWS; r++) begin
            send(row_word(r, fl, longint'(signed'($urandom()))), 0, '0);
            case ($urandom_range(0, 9))
                0: ;
                1: fl = fl + $urandom_range(0, 32'h3FFF_FFFF);
                default: fl = fl + $urandom_range(1, 32'h0040_0000);
            endcase
            if (fl > 64'h7FFF_FFFF) fl = 64'h7FFF_FFFF;
        end
    endtask

    function automatic in_t random_query();
        longint q;
        logic [31:0] lsv, lmv;
        case ($urandom_range(0, 9))
            0: q = -longint'($urandom_range(0, 32'h7FFF_FFFF)) - 1;
            1: q = 0;
            2: q = $urandom_range(0, 32'h7FFF_FFFF);
            default: q = $urandom_range(0, 32'(tab_flow[MAX_ROWS-1] + 32'h0100_0000));
        endcase
        if (q > S_HI) q = S_HI;
        lsv = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom();
        lmv = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom();
        if ($urandom_range(0, 1)) begin
            lsv = 32'(bed + $urandom_range(0, 1000) - 500);
            lmv = 32'(ref_n + $urandom_range(0, 1000) - 500);
        end
        return query_word(q, $urandom_range(0, 1), lsv, $urandom_range(0, 1), lmv);
    endfunction

    typedef struct {
        in_t  w;
        bit   has_exp;
        out_t exp_v;
    } stim_row_t;

    initial begin
        stim_row_t stim[$];
        stim_row_t s;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // row 0 and copies of row 1 span the extremes so they are easy to read off
        s.has_exp = 0; s.exp_v = '0;
        s.w = '0; s.w.op = OP_WRITE; s.w.row = 0; s.w.row_flow = 0;
        s.w.row_stage = 32'sh8000_0000; s.w.row_width = 31'h7FFF_FFFF;
        s.w.row_area = 0; s.w.row_perimeter = 31'h7FFF_FFFF; stim.push_back(s);
        s.w.row = 1; s.w.row_flow = 31'h7FFF_FFFF; s.w.row_stage = 32'sh7FFF_FFFF;
        s.w.row_width = 0; s.w.row_area = 31'h7FFF_FFFF; s.w.row_perimeter = 0;
        stim.push_back(s);
        s.w.row = 31; s.w.row_flow = 31'h7FFF_FFFF; stim.push_back(s);
        for (int r = 2; r < 20; r++) begin
            s.w.row = 5'(r); s.w.row_flow = 31'h7FFF_FFFF; stim.push_back(s);
        end
        // negative flow: row 0 values, status nonpositive
        s.w = query_word(32'sh8000_0000, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
        s.has_exp = 1;
        s.exp_v = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0,
                    32'h7FFF_FFFF, 32'd0, 32'd0, STAT_NONPOS};
        stim.push_back(s);
        s.has_exp = 0;
        s.w = query_word(0, 0, 1, 0, 1); stim.push_back(s);
        s.w = query_word(32'sh7FFF_FFFF, 0, 1, 0, 1); stim.push_back(s);
        s.w = query_word(32'sh4000_0000, 1, 0, 0, 1); stim.push_back(s);
        s.w = query_word(32'sh0001_0000, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
        stim.push_back(s);
        s.w = query_word(32'sh0001_0000, 0, 32'h1, 1, 32'h0); stim.push_back(s);
        foreach (stim[i]) send(stim[i].w, stim[i].has_exp, stim[i].exp_v);

        // zero reference roughness with the local factor in use
        write_reg(REG_REF_N, 32'd0);
        send(query_word(32'sh0002_0000, 0, 1, 1, 32'h1000_0000), 0, '0);
        write_reg(REG_POINTS, 32'd0);
        send(query_word(32'sh0002_0000, 0, 1, 0, 1), 0, '0);

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            sink_random = (ph != 3);
            write_reg(REG_POINTS, ph == 0 ? 32'd2 : (ph == 1 ? 32'd63 : (ph == 2 ? 32'd32
                                  : $urandom_range(0, 63))));
            write_reg(REG_BED_SLOPE, ph == 0 ? 32'd1 : (ph == 1 ? 32'hFFFF_FFFF
                                     : (ph == 5 ? 32'd0 : $urandom_range(1000, 32'h2000_0000))));
            write_reg(REG_REF_N, ph == 1 ? 32'hFFFF_FFFF : (ph == 2 ? 32'd1
                                 : $urandom_range(1000, 32'h2000_0000)));
            write_reg(REG_MIN_STAGE, ph == 0 ? 32'h8000_0000 : (ph == 1 ? 32'h7FFF_FFFF
                                     : $urandom()));
            load_table();
            for (int i = 0; i < 160; i++) begin
                if ($urandom_range(0, 19) == 0)
                    send(row_word($urandom_range(0, 31), $urandom(),
                                  longint'(signed'($urandom()))), 0, '0);
                else
                    send(random_query(), 0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (800) @(posedge aclk);
        if (errors == 0)
            $display("rating_curve_interpolator_top verification clean");
        else
            $display("rating_curve_interpolator_top verification failed");
        $finish;
    end
endmodule
